// File: rtl/e131dmx_pkg.sv
// shared types, constants and the acn identifier table for the sacn packet parser
// no dependencies; used by every rtl file of the block
`timescale 1ns / 1ps

package e131dmx_pkg;

    localparam int MAX_SLOTS        = 512;
    localparam int MAX_PACKET_BYTES = 638;

    localparam int POS_W       = 10;
    localparam int UNI_W       = 16;
    localparam int IDX_W       = 9;
    localparam int CNT_W       = 10;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE_FIRST = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNIVERSE_COUNT = 1'b1;

    localparam logic [31:0] ROOT_DATA  = 32'h0000_0004;
    localparam logic [31:0] ROOT_SYNC  = 32'h0000_0008;
    localparam logic [31:0] FRAME_DATA = 32'h0000_0002;
    localparam logic [31:0] FRAME_SYNC = 32'h0000_0001;
    localparam logic [7:0]  DMP_VECTOR = 8'h02;
    localparam logic [7:0]  PREVIEW_BIT = 8'h80;

    localparam logic [POS_W-1:0] POS_IDENT_FIRST = 10'd4;
    localparam logic [POS_W-1:0] POS_IDENT_LAST  = 10'd15;
    localparam logic [POS_W-1:0] POS_ROOT_FIRST  = 10'd18;
    localparam logic [POS_W-1:0] POS_ROOT_LAST   = 10'd21;
    localparam logic [POS_W-1:0] POS_FRAME_FIRST = 10'd40;
    localparam logic [POS_W-1:0] POS_FRAME_LAST  = 10'd43;
    localparam logic [POS_W-1:0] POS_SYNC_UNI_HI = 10'd45;
    localparam logic [POS_W-1:0] POS_SYNC_UNI_LO = 10'd46;
    localparam logic [POS_W-1:0] POS_SEQUENCE    = 10'd111;
    localparam logic [POS_W-1:0] POS_OPTIONS     = 10'd112;
    localparam logic [POS_W-1:0] POS_UNI_HI      = 10'd113;
    localparam logic [POS_W-1:0] POS_UNI_LO      = 10'd114;
    localparam logic [POS_W-1:0] POS_DMP_VECTOR  = 10'd117;
    localparam logic [POS_W-1:0] POS_PROP_HI     = 10'd123;
    localparam logic [POS_W-1:0] POS_PROP_LO     = 10'd124;
    localparam logic [POS_W-1:0] POS_VALUES_AT   = 10'd125;
    localparam logic [POS_W-1:0] POS_SLOTS_AT    = 10'd126;
    localparam logic [POS_W-1:0] MIN_SYNC_LEN    = 10'd49;
    localparam logic [POS_W-1:0] MIN_DATA_LEN    = 10'd126;

    typedef enum logic [1:0] {
        KIND_SLOT = 2'd0,
        KIND_DONE = 2'd1,
        KIND_SYNC = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [UNI_W-1:0]  universe;
        logic [IDX_W-1:0]  slot_index;
        logic [7:0]        slot_value;
        logic [7:0]        sequence_res;
        logic [CNT_W-1:0]  slot_count;
        logic              run_last;
    } res_t;

    // up to two results per byte; v1 is only set together with v0
    typedef struct packed {
        logic v0;
        res_t r0;
        logic v1;
        res_t r1;
    } res_pair_t;

    // "ASC-E1.17" followed by three nul bytes
    function automatic logic [7:0] acn_ident_byte(input logic [3:0] i);
        logic [7:0] c;
        unique case (i)
            4'd0:    c = 8'h41;
            4'd1:    c = 8'h53;
            4'd2:    c = 8'h43;
            4'd3:    c = 8'h2D;
            4'd4:    c = 8'h45;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2E;
            4'd7:    c = 8'h31;
            4'd8:    c = 8'h37;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/e131_dmx_packet_parser_unit.sv
// top level of the sacn packet parser: input register, config registers, parser, result queue
// depends on e131dmx_pkg, e131dmx_parser and e131dmx_res_fifo
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata payload_byte, tlast end_of_packet
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata result fields, tuser kind, tlast run_last
// cfg       in         cfg_valid/cfg_ready           cfg_index register, cfg_data value
//
// one byte a cycle sustained while the result queue has room; a result passes the input register,
// then goes from the parser into the result queue
// an end byte may give two results, which the four-entry queue absorbs while bytes keep coming
// stalls on m_axis back up into s_axis once fewer than two queue entries are free
// reset is synchronous and active low; cfg_ready is always high
`timescale 1ns / 1ps

module e131_dmx_packet_parser_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,  // payload_byte
    input  logic                                s_axis_tlast,  // end_of_packet
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // universe, slot_index, slot_value, sequence_res, slot_count, zero fill
    output logic [e131dmx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,  // kind
    output logic                                m_axis_tlast,  // run_last
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [e131dmx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [e131dmx_pkg::UNI_W-1:0]       cfg_data
);
    import e131dmx_pkg::*;

    logic             in_v_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic [UNI_W-1:0] universe_first_reg;
    logic [UNI_W-1:0] universe_count_reg;
    logic             room;
    logic             advance;
    res_pair_t        res_pair;
    res_pair_t        push;
    res_t             head;

    assign cfg_ready     = 1'b1;
    assign advance       = in_v_reg && room;
    assign s_axis_tready = !in_v_reg || room;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            universe_first_reg <= 16'd1;
            universe_count_reg <= 16'd1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_UNIVERSE_FIRST: universe_first_reg <= cfg_data;
                CFG_UNIVERSE_COUNT: universe_count_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_v_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    e131dmx_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .byte_in        (in_byte_reg),
        .last_in        (in_last_reg),
        .universe_first (universe_first_reg),
        .universe_count (universe_count_reg),
        .res_out        (res_pair)
    );

    always_comb begin
        push    = res_pair;
        push.v0 = res_pair.v0 && advance;
        push.v1 = res_pair.v1 && advance;
    end

    e131dmx_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (head)
    );

    assign m_axis_tdata = {5'b0, head.slot_count, head.sequence_res, head.slot_value,
                           head.slot_index, head.universe};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.run_last;

endmodule

// File: rtl/e131dmx_parser.sv
// packet header checks, per-packet state and result generation for one byte a cycle while advance is high
// depends on e131dmx_pkg
`timescale 1ns / 1ps

module e131dmx_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic [7:0]                    byte_in,
    input  logic                          last_in,
    input  logic [e131dmx_pkg::UNI_W-1:0] universe_first,
    input  logic [e131dmx_pkg::UNI_W-1:0] universe_count,
    output e131dmx_pkg::res_pair_t        res_out
);
    import e131dmx_pkg::*;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             good_reg, good_next;
    logic [31:0]      root_reg, root_next;
    logic [31:0]      frame_reg, frame_next;
    logic [UNI_W-1:0] uni_reg, uni_next;
    logic [15:0]      prop_reg, prop_next;
    logic [7:0]       seq_reg, seq_next;
    logic [CNT_W-1:0] sent_reg, sent_next;

    logic [POS_W-1:0] slot_idx;
    logic [3:0]       ident_idx;
    logic [UNI_W:0]   window_top;
    logic             slot_hit;
    logic             end_hit;
    logic             end_sync;
    logic [UNI_W-1:0] end_uni;
    logic [7:0]       end_seq;
    logic [CNT_W-1:0] end_cnt;
    res_t             slot_res;
    res_t             end_res;

    always_comb begin
        pos_next   = pos_reg;
        good_next  = good_reg;
        root_next  = root_reg;
        frame_next = frame_reg;
        uni_next   = uni_reg;
        prop_next  = prop_reg;
        seq_next   = seq_reg;
        sent_next  = sent_reg;
        slot_hit   = 1'b0;
        end_hit    = 1'b0;
        slot_idx   = pos_reg - POS_SLOTS_AT;
        ident_idx  = 4'(pos_reg - POS_IDENT_FIRST);
        window_top = {1'b0, universe_first} + {1'b0, universe_count};

        if (advance && (pos_reg < POS_W'(MAX_PACKET_BYTES))) begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg >= POS_IDENT_FIRST && pos_reg <= POS_IDENT_LAST) begin
                if (byte_in != acn_ident_byte(ident_idx)) good_next = 1'b0;
            end else if (pos_reg >= POS_ROOT_FIRST && pos_reg <= POS_ROOT_LAST) begin
                root_next = {root_reg[23:0], byte_in};
                if (pos_reg == POS_ROOT_LAST && root_next != ROOT_DATA
                        && root_next != ROOT_SYNC) good_next = 1'b0;
            end else if (pos_reg >= POS_FRAME_FIRST && pos_reg <= POS_FRAME_LAST) begin
                frame_next = {frame_reg[23:0], byte_in};
                if (pos_reg == POS_FRAME_LAST
                        && frame_next != ((root_reg == ROOT_SYNC) ? FRAME_SYNC : FRAME_DATA))
                    good_next = 1'b0;
            end

            if (root_next == ROOT_SYNC) begin
                if (pos_reg == POS_SYNC_UNI_HI || pos_reg == POS_SYNC_UNI_LO)
                    uni_next = {uni_reg[7:0], byte_in};
            end else if (root_next == ROOT_DATA) begin
                if (pos_reg == POS_SEQUENCE) begin
                    seq_next = byte_in;
                end else if (pos_reg == POS_OPTIONS) begin
                    if ((byte_in & PREVIEW_BIT) != 8'h00) good_next = 1'b0;
                end else if (pos_reg == POS_UNI_HI || pos_reg == POS_UNI_LO) begin
                    uni_next = {uni_reg[7:0], byte_in};
                    // window computed one bit wider so it never wraps
                    if (pos_reg == POS_UNI_LO
                            && ({1'b0, uni_next} < {1'b0, universe_first}
                                || {1'b0, uni_next} >= window_top))
                        good_next = 1'b0;
                end else if (pos_reg == POS_DMP_VECTOR) begin
                    if (byte_in != DMP_VECTOR) good_next = 1'b0;
                end else if (pos_reg == POS_PROP_HI || pos_reg == POS_PROP_LO) begin
                    prop_next = {prop_reg[7:0], byte_in};
                    if (pos_reg == POS_PROP_LO && prop_next < 16'd2) good_next = 1'b0;
                end else if (pos_reg == POS_VALUES_AT) begin
                    if (byte_in != 8'h00) good_next = 1'b0;
                end else if (pos_reg >= POS_SLOTS_AT && good_reg) begin
                    if ((16'(slot_idx) + 16'd1 < prop_reg)
                            && ({1'b0, slot_idx} < (POS_W+1)'(MAX_SLOTS))) begin
                        slot_hit  = 1'b1;
                        sent_next = sent_reg + 1'b1;
                    end
                end
            end
        end

        // values this byte leaves behind, taken before the end byte clears them
        end_sync = (root_next == ROOT_SYNC);
        end_uni  = uni_next;
        end_seq  = seq_next;
        end_cnt  = sent_next;

        if (advance && last_in) begin
            if (good_next && root_next == ROOT_SYNC && pos_next >= MIN_SYNC_LEN)
                end_hit = 1'b1;
            if (good_next && root_next == ROOT_DATA && pos_next >= MIN_DATA_LEN
                    && sent_next != '0)
                end_hit = 1'b1;
            pos_next   = '0;
            good_next  = 1'b1;
            root_next  = '0;
            frame_next = '0;
            uni_next   = '0;
            prop_next  = '0;
            seq_next   = '0;
            sent_next  = '0;
        end
    end

    always_comb begin
        slot_res.kind         = KIND_SLOT;
        slot_res.universe     = uni_reg;
        slot_res.slot_index   = slot_idx[IDX_W-1:0];
        slot_res.slot_value   = byte_in;
        slot_res.sequence_res = seq_reg;
        slot_res.slot_count   = '0;
        slot_res.run_last     = !end_hit;

        end_res.run_last   = 1'b1;
        end_res.slot_index = '0;
        end_res.slot_value = '0;
        end_res.universe   = end_uni;
        if (end_sync) begin
            end_res.kind         = KIND_SYNC;
            end_res.sequence_res = '0;
            end_res.slot_count   = '0;
        end else begin
            end_res.kind         = KIND_DONE;
            end_res.sequence_res = end_seq;
            end_res.slot_count   = end_cnt;
        end

        res_out.v0 = slot_hit || end_hit;
        res_out.r0 = slot_hit ? slot_res : end_res;
        res_out.v1 = slot_hit && end_hit;
        res_out.r1 = end_res;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            good_reg  <= 1'b1;
            root_reg  <= '0;
            frame_reg <= '0;
            uni_reg   <= '0;
            prop_reg  <= '0;
            seq_reg   <= '0;
            sent_reg  <= '0;
        end else begin
            pos_reg   <= pos_next;
            good_reg  <= good_next;
            root_reg  <= root_next;
            frame_reg <= frame_next;
            uni_reg   <= uni_next;
            prop_reg  <= prop_next;
            seq_reg   <= seq_next;
            sent_reg  <= sent_next;
        end
    end

endmodule

// File: rtl/e131dmx_res_fifo.sv
// small result queue: up to two pushes and one pop per cycle
// depends on e131dmx_pkg
`timescale 1ns / 1ps

module e131dmx_res_fifo (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  e131dmx_pkg::res_pair_t push,
    output logic                   room,
    output logic                   out_valid,
    input  logic                   out_ready,
    output e131dmx_pkg::res_t      out_res
);
    import e131dmx_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_PTR_W-1:0] wr_ptr_plus1;
    logic [1:0]            push_n;
    logic                  pop;

    // room for a full pair of results
    assign room         = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid    = count_reg != '0;
    assign out_res      = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign push_n       = {1'b0, push.v0} + {1'b0, push.v1};

    always_comb begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.v0) mem_reg[wr_ptr_reg] <= push.r0;
        if (push.v1) mem_reg[wr_ptr_plus1] <= push.r1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/e131dmx_checker.sv
// port-level checks for the sacn packet parser, bound to the top level
// depends on e131dmx_pkg and e131_dmx_packet_parser_unit
`timescale 1ns / 1ps

module e131dmx_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [e131dmx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                          m_axis_tuser,
    input logic                                m_axis_tlast
);
    import e131dmx_pkg::*;

    // a stalled result request holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // only slot results carry slot index and level
    a_slot_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != KIND_SLOT |-> m_axis_tdata[32:16] == '0)
        else $error("slot fields set on a non-slot result");

    // sync closes its byte and has no sequence or count
    a_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_SYNC |-> m_axis_tlast
            && m_axis_tdata[50:33] == '0)
        else $error("bad sync result");

    // frame done closes its byte and reports at least one slot
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast
            && m_axis_tdata[50:41] != '0)
        else $error("bad frame-done result");

endmodule

bind e131_dmx_packet_parser_unit e131dmx_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/testbench.sv
// self-checking testbench for the sacn packet parser: a scoreboard class predicts every result
// from the bytes taken, plain tasks drive the byte and register channels
// depends on e131dmx_pkg and e131_dmx_packet_parser_unit
`timescale 1ns / 1ps

module testbench;

    import e131dmx_pkg::*;

    localparam logic [7:0] ACN_ID [0:11] = '{8'h41, 8'h53, 8'h43, 8'h2D, 8'h45, 8'h31,
                                             8'h2E, 8'h31, 8'h37, 8'h00, 8'h00, 8'h00};

    typedef enum int {
        FLAW_NONE,
        FLAW_IDENT,
        FLAW_ROOT,
        FLAW_FRAMING,
        FLAW_PREVIEW,
        FLAW_DMP,
        FLAW_PROPS,
        FLAW_START,
        FLAW_TRUNC
    } flaw_t;

    class dmx_result_predictor;
        res_t        awaited_results[$];
        int unsigned win_first = 1;
        int unsigned win_count = 1;
        logic [9:0]  pos;
        bit          hdr_ok;
        logic [31:0] root_vec;
        logic [31:0] frame_vec;
        logic [15:0] uni;
        logic [15:0] props;
        logic [7:0]  seq;
        logic [9:0]  slots;
        int unsigned errors;
        int unsigned slot_hits;
        int unsigned done_hits;
        int unsigned sync_hits;

        function new();
            clear_packet();
        endfunction

        function void clear_packet();
            pos       = '0;
            hdr_ok    = 1'b1;
            root_vec  = '0;
            frame_vec = '0;
            uni       = '0;
            props     = '0;
            seq       = '0;
            slots     = '0;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
            if (idx == CFG_UNIVERSE_FIRST) win_first = 32'(val);
            else win_count = 32'(val);
        endfunction

        function res_t make_result(kind_t k, logic [15:0] u, logic [8:0] idx, logic [7:0] val,
                                   logic [7:0] sq, logic [9:0] cnt);
            res_t r;
            r              = '0;
            r.kind         = k;
            r.universe     = u;
            r.slot_index   = idx;
            r.slot_value   = val;
            r.sequence_res = sq;
            r.slot_count   = cnt;
            return r;
        endfunction

        // works out what one accepted byte causes and queues it
        function void note_byte(logic [7:0] b, bit last);
            res_t        made [2];
            int          n;
            int unsigned idx;
            n = 0;
            if (pos < MAX_PACKET_BYTES) begin
                if (pos >= POS_IDENT_FIRST && pos <= POS_IDENT_LAST) begin
                    if (b != ACN_ID[pos - POS_IDENT_FIRST]) hdr_ok = 1'b0;
                end else if (pos >= POS_ROOT_FIRST && pos <= POS_ROOT_LAST) begin
                    root_vec = {root_vec[23:0], b};
                    if (pos == POS_ROOT_LAST && root_vec != ROOT_DATA && root_vec != ROOT_SYNC)
                        hdr_ok = 1'b0;
                end else if (pos >= POS_FRAME_FIRST && pos <= POS_FRAME_LAST) begin
                    frame_vec = {frame_vec[23:0], b};
                    if (pos == POS_FRAME_LAST &&
                        frame_vec != ((root_vec == ROOT_SYNC) ? FRAME_SYNC : FRAME_DATA))
                        hdr_ok = 1'b0;
                end

                if (root_vec == ROOT_SYNC) begin
                    if (pos == POS_SYNC_UNI_HI || pos == POS_SYNC_UNI_LO) uni = {uni[7:0], b};
                end else if (root_vec == ROOT_DATA) begin
                    case (pos)
                        POS_SEQUENCE: seq = b;
                        POS_OPTIONS:  if ((b & PREVIEW_BIT) != 0) hdr_ok = 1'b0;
                        POS_UNI_HI:   uni = {uni[7:0], b};
                        POS_UNI_LO: begin
                            uni = {uni[7:0], b};
                            // window check without wrap
                            if (uni < win_first || uni >= win_first + win_count) hdr_ok = 1'b0;
                        end
                        POS_DMP_VECTOR: if (b != DMP_VECTOR) hdr_ok = 1'b0;
                        POS_PROP_HI:    props = {props[7:0], b};
                        POS_PROP_LO: begin
                            props = {props[7:0], b};
                            if (props < 2) hdr_ok = 1'b0;
                        end
                        POS_VALUES_AT: if (b != 8'h00) hdr_ok = 1'b0;
                        default: begin
                            if (pos >= POS_SLOTS_AT && hdr_ok) begin
                                idx = pos - POS_SLOTS_AT;
                                if (idx + 1 < props && idx < MAX_SLOTS) begin
                                    made[n] = make_result(KIND_SLOT, uni, idx[8:0], b, seq, '0);
                                    n++;
                                    slots++;
                                end
                            end
                        end
                    endcase
                end
                pos++;
            end

            if (last) begin
                if (hdr_ok) begin
                    if (root_vec == ROOT_SYNC && pos >= MIN_SYNC_LEN) begin
                        made[n] = make_result(KIND_SYNC, uni, '0, '0, '0, '0);
                        n++;
                    end else if (root_vec == ROOT_DATA && pos >= MIN_DATA_LEN && slots >= 1) begin
                        made[n] = make_result(KIND_DONE, uni, '0, '0, seq, slots);
                        n++;
                    end
                end
                clear_packet();
            end

            if (n > 0) made[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++) awaited_results.push_back(made[i]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d universe %0d", got.kind, got.universe);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("universe", want.universe, got.universe);
            compare_field("slot_index", want.slot_index, got.slot_index);
            compare_field("slot_value", want.slot_value, got.slot_value);
            compare_field("sequence_res", want.sequence_res, got.sequence_res);
            compare_field("slot_count", want.slot_count, got.slot_count);
            compare_field("run_last", want.run_last, got.run_last);
            case (want.kind)
                KIND_SLOT: slot_hits++;
                KIND_DONE: done_hits++;
                default:   sync_hits++;
            endcase
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [UNI_W-1:0]      cfg_data;

    dmx_result_predictor board = new();

    logic [7:0]  image [0:1023];
    bit          gaps_on = 1'b1;
    int unsigned cur_first = 1;
    int unsigned cur_count = 1;
    int unsigned bytes_sent;
    int unsigned packets_sent;

    e131_dmx_packet_parser_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // result side: random back-pressure, changed on the falling edge
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready = !gaps_on || ($urandom_range(99) >= 17);
        end
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got              = '0;
            got.kind         = kind_t'(m_axis_tuser);
            got.universe     = m_axis_tdata[15:0];
            got.slot_index   = m_axis_tdata[24:16];
            got.slot_value   = m_axis_tdata[32:25];
            got.sequence_res = m_axis_tdata[40:33];
            got.slot_count   = m_axis_tdata[50:41];
            got.run_last     = m_axis_tlast;
            board.check_result(got);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        board.note_register(idx, val);
        if (idx == CFG_UNIVERSE_FIRST) cur_first = 32'(val);
        else cur_count = 32'(val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_byte(logic [7:0] b, bit last);
        @(negedge aclk);
        if (gaps_on && $urandom_range(99) < 10) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        s_axis_tlast  = last;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet(int len);
        for (int i = 0; i < len; i++) send_byte(image[i], i == len - 1);
        packets_sent++;
    endtask

    // random bytes, then the identifier and both vectors
    task automatic fill_image(logic [31:0] root_v, logic [31:0] frame_v);
        for (int i = 0; i < 1024; i++) image[i] = 8'($urandom_range(255));
        for (int i = 0; i < 12; i++) image[POS_IDENT_FIRST + i] = ACN_ID[i];
        for (int i = 0; i < 4; i++) begin
            image[POS_ROOT_FIRST + i]  = root_v[31 - 8*i -: 8];
            image[POS_FRAME_FIRST + i] = frame_v[31 - 8*i -: 8];
        end
    endtask

    task automatic break_header(flaw_t flaw);
        case (flaw)
            FLAW_IDENT:   image[$urandom_range(4, 15)]  ^= 8'($urandom_range(1, 255));
            FLAW_ROOT:    image[$urandom_range(18, 21)] ^= 8'($urandom_range(1, 255));
            FLAW_FRAMING: image[$urandom_range(40, 43)] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
    endtask

    task automatic send_data(logic [15:0] u, logic [7:0] sq, int nslots, logic [15:0] prop,
                             flaw_t flaw);
        int len;
        len = POS_SLOTS_AT + nslots;
        fill_image(ROOT_DATA, FRAME_DATA);
        if (flaw == FLAW_PROPS) prop = 16'($urandom_range(1));
        image[POS_SEQUENCE]   = sq;
        image[POS_OPTIONS]    = image[POS_OPTIONS] & ~PREVIEW_BIT;
        image[POS_UNI_HI]     = u[15:8];
        image[POS_UNI_LO]     = u[7:0];
        image[POS_DMP_VECTOR] = DMP_VECTOR;
        image[POS_PROP_HI]    = prop[15:8];
        image[POS_PROP_LO]    = prop[7:0];
        image[POS_VALUES_AT]  = 8'h00;
        break_header(flaw);
        case (flaw)
            FLAW_PREVIEW: image[POS_OPTIONS]    |= PREVIEW_BIT;
            FLAW_DMP:     image[POS_DMP_VECTOR] ^= 8'($urandom_range(1, 255));
            FLAW_START:   image[POS_VALUES_AT]   = 8'($urandom_range(1, 255));
            FLAW_TRUNC:   len = $urandom_range(1, 125);
            default: ;
        endcase
        send_packet(len);
    endtask

    task automatic send_sync(logic [15:0] u, int len, flaw_t flaw);
        fill_image(ROOT_SYNC, FRAME_SYNC);
        image[POS_SYNC_UNI_HI] = u[15:8];
        image[POS_SYNC_UNI_LO] = u[7:0];
        break_header(flaw);
        if (flaw == FLAW_TRUNC) len = $urandom_range(1, 48);
        send_packet(len);
    endtask

    task automatic send_noise(int len);
        for (int i = 0; i < len; i++) image[i] = 8'($urandom_range(255));
        send_packet(len);
    endtask

    // mostly inside the window, with its edges and stray universes too
    function automatic logic [15:0] pick_universe();
        int unsigned top;
        int unsigned r;
        top = cur_first + cur_count;
        if (top > 65536) top = 65536;
        r = $urandom_range(9);
        if (r < 6 && top > cur_first) return 16'($urandom_range(cur_first, top - 1));
        if (r == 6) return 16'(cur_first - 1);
        if (r == 7) return 16'(top);
        if (r == 8) return 16'(cur_first);
        return 16'($urandom_range(65535));
    endfunction

    task automatic send_random_packet();
        int   pick;
        int   nslots;
        int   prop;
        pick   = $urandom_range(99);
        nslots = ($urandom_range(9) < 8) ? $urandom_range(0, 10) : $urandom_range(11, 60);
        prop   = nslots + 1;
        if ($urandom_range(99) < 15) prop = $urandom_range(2, 600);
        if (pick < 55)
            send_data(pick_universe(), 8'($urandom_range(255)), nslots, 16'(prop), FLAW_NONE);
        else if (pick < 65)
            send_sync(16'($urandom_range(65535)), $urandom_range(49, 80), FLAW_NONE);
        else if (pick < 82)
            send_data(pick_universe(), 8'($urandom_range(255)), nslots, 16'(prop),
                      flaw_t'($urandom_range(FLAW_IDENT, FLAW_TRUNC)));
        else if (pick < 90)
            send_sync(16'($urandom_range(65535)), $urandom_range(49, 80),
                      flaw_t'($urandom_range(FLAW_IDENT, FLAW_FRAMING)));
        else if (pick < 95)
            send_sync(16'($urandom_range(65535)), 1, FLAW_TRUNC);
        else
            send_noise($urandom_range(1, 60));
    endtask

    task automatic settle();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (board.awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    initial begin
        logic [15:0] phase_first [6];
        logic [15:0] phase_count [6];

        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_UNIVERSE_FIRST;
        cfg_data      = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed packets at the reset window of universe 1 only
        send_data(16'd1, 8'd0, 1, 16'd2, FLAW_NONE);       // slot and frame end on one byte
        send_sync(16'd300, 49, FLAW_NONE);
        send_sync(16'hFFFF, 48, FLAW_NONE);                // one byte short
        settle();

        phase_first = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        phase_count = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000};
        phase_first[4] = 16'($urandom_range(65535));
        phase_count[4] = 16'($urandom_range(1, 20));
        phase_first[5] = 16'($urandom_range(65535));
        phase_count[5] = 16'($urandom_range(65535));

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_UNIVERSE_FIRST, phase_first[ph]);
            write_reg(CFG_UNIVERSE_COUNT, phase_count[ph]);
            gaps_on = (ph != 2);  // one long run at full rate on both sides
            // the full-rate run carries a full universe with its end marker past the byte limit
            if (ph == 2) send_data(16'd1, 8'd3, 513, 16'd600, FLAW_NONE);
            else send_random_packet();
            settle();
        end

        gaps_on = 1'b1;
        repeat (12) @(posedge aclk);
        $display("%0d bytes in %0d packets over 7 universe windows", bytes_sent, packets_sent);
        $display("checked %0d slot values, %0d frame ends, %0d sync reports",
                 board.slot_hits, board.done_hits, board.sync_hits);
        if (board.errors == 0 && board.awaited_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
